// ----- hdl/orb_pkg.sv -----
// types and constants shared by the overwrite-oldest ring buffer modules
// no dependencies
`default_nettype none

package orb_pkg;

    // fixed field widths
    localparam int WORD_W = 32;
    localparam int MODE_W = 2;
    localparam int LEN_W  = 7;

    // buffer_length after reset
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd8;

    // register index of buffer_length, taken from paddr[2]
    localparam logic REG_BUFFER_LENGTH = 1'b0;

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_INSERT,
        CMD_DUMP,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [WORD_W-1:0]  value;
    } cmd_t;

    // back-end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_DUMP
    } bk_state_t;

endpackage

`default_nettype wire

// ----- hdl/orb_ram.sv -----
// generic simple dual-port ram with registered read
// no dependencies
`default_nettype none

module orb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/orb_front.sv -----
// input side: accepts items, classifies the mode and queues commands
// depends on orb_pkg
`default_nettype none

module orb_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [orb_pkg::MODE_W-1:0] in_mode,
    input  wire logic [orb_pkg::WORD_W-1:0] in_value,
    output logic                            cmd_valid,
    input  wire logic                       cmd_ready,
    output orb_pkg::cmd_t                   cmd
);

    import orb_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] occ_reg;
    logic [1:0] occ_next;
    logic       known;
    cmd_kind_t  kind;
    logic       push;
    logic       pop;

    // mode decode, unused code is dropped
    always_comb
    begin
        known = 1'b1;
        kind  = CMD_INSERT;
        unique case (in_mode)
            MODE_INSERT: kind = CMD_INSERT;
            MODE_DUMP:   kind = CMD_DUMP;
            MODE_CLEAR:  kind = CMD_CLEAR;
            default:     known = 1'b0;
        endcase
    end

    assign in_ready  = (occ_reg != 2'd2);
    assign push      = in_valid && in_ready && known;
    assign cmd_valid = (occ_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        occ_next    = occ_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            occ_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    // queue entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{kind: kind, value: in_value};
        end
    end

endmodule

`default_nettype wire

// ----- hdl/orb_back.sv -----
// back end: ring pointers, word store, dump sequencer and result queue
// depends on orb_pkg and orb_ram
`default_nettype none

module orb_back #(
    parameter int MAX_DEPTH = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [$clog2(MAX_DEPTH+1)-1:0]     cap,
    input  wire logic                               cfg_clear,
    input  wire logic                               cmd_valid,
    output logic                                    cmd_ready,
    input  wire orb_pkg::cmd_t                      cmd,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [orb_pkg::WORD_W-1:0]              out_word,
    output logic                                    out_real,
    output logic                                    out_last
);

    import orb_pkg::*;

    localparam int IDX_W = $clog2(MAX_DEPTH);
    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    bk_state_t         state_reg;
    bk_state_t         state_next;
    logic [IDX_W-1:0]  oldest_reg;
    logic [IDX_W-1:0]  oldest_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W-1:0]  rd_ptr_reg;
    logic [IDX_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  rd_left_reg;
    logic [CNT_W-1:0]  rd_left_next;
    logic              inflight_reg;
    logic              inflight_real_reg;
    logic              inflight_last_reg;
    logic              issue;
    logic              issue_ok;
    logic              wr_en;
    logic              rd_en;
    logic [SUM_W-1:0]  wr_sum;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] rd_data;

    // result queue, two entries
    logic [WORD_W-1:0] oq_word_reg [2];
    logic              oq_real_reg [2];
    logic              oq_last_reg [2];
    logic              oq_wr_reg;
    logic              oq_rd_reg;
    logic [1:0]        oq_occ_reg;
    logic              oq_pop;
    logic [2:0]        credit;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(MAX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // slot after the newest word, wrapped once
    assign wr_sum  = {1'b0, oldest_reg} + SUM_W'(count_reg);
    assign wr_addr = (wr_sum >= SUM_W'(MAX_DEPTH)) ? IDX_W'(wr_sum - SUM_W'(MAX_DEPTH))
                                                   : IDX_W'(wr_sum);

    // a read may issue when queued plus in-flight results leave a free slot
    assign oq_pop   = out_valid && out_ready;
    assign credit   = {1'b0, oq_occ_reg} + {2'b00, inflight_reg} - {2'b00, oq_pop};
    assign issue_ok = (credit < 3'd2);

    assign cmd_ready = (state_reg == BK_IDLE);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        oldest_next  = oldest_reg;
        count_next   = count_reg;
        rd_ptr_next  = rd_ptr_reg;
        rd_left_next = rd_left_reg;
        issue        = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_INSERT:
                        begin
                            wr_en = 1'b1;
                            if (count_reg >= cap)
                            begin
                                oldest_next = idx_inc(oldest_reg);
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_DUMP:
                        begin
                            rd_ptr_next  = oldest_reg;
                            rd_left_next = count_reg;
                            state_next   = BK_DUMP;
                        end
                        CMD_CLEAR:
                        begin
                            oldest_next = '0;
                            count_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_DUMP:
            begin
                // an empty store gives one flagged result
                if (issue_ok)
                begin
                    issue       = 1'b1;
                    rd_en       = (rd_left_reg != '0);
                    rd_ptr_next = idx_inc(rd_ptr_reg);
                    if (rd_left_reg <= CNT_W'(1))
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        rd_left_next = rd_left_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        if (cfg_clear)
        begin
            oldest_next = '0;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            oldest_reg   <= '0;
            count_reg    <= '0;
            rd_ptr_reg   <= '0;
            rd_left_reg  <= '0;
            inflight_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            oldest_reg   <= oldest_next;
            count_reg    <= count_next;
            rd_ptr_reg   <= rd_ptr_next;
            rd_left_reg  <= rd_left_next;
            inflight_reg <= issue;
        end
    end

    // flags travel beside the ram read
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            inflight_real_reg <= (rd_left_reg != '0);
            inflight_last_reg <= (rd_left_reg <= CNT_W'(1));
        end
    end

    orb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.value),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    // result queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= 1'b0;
            oq_rd_reg  <= 1'b0;
            oq_occ_reg <= 2'd0;
        end
        else
        begin
            oq_wr_reg  <= inflight_reg ? ~oq_wr_reg : oq_wr_reg;
            oq_rd_reg  <= oq_pop ? ~oq_rd_reg : oq_rd_reg;
            oq_occ_reg <= oq_occ_reg + {1'b0, inflight_reg} - {1'b0, oq_pop};
        end
    end

    // result queue entries
    always_ff @(posedge clk)
    begin
        if (inflight_reg)
        begin
            oq_word_reg[oq_wr_reg] <= inflight_real_reg ? rd_data : '0;
            oq_real_reg[oq_wr_reg] <= inflight_real_reg;
            oq_last_reg[oq_wr_reg] <= inflight_last_reg;
        end
    end

    assign out_valid = (oq_occ_reg != 2'd0);
    assign out_word  = oq_word_reg[oq_rd_reg];
    assign out_real  = oq_real_reg[oq_rd_reg];
    assign out_last  = oq_last_reg[oq_rd_reg];

endmodule

`default_nettype wire

// ----- hdl/overwrite_oldest_ring_buffer_core.sv -----
// Ring buffer of signed 32-bit words that keeps the newest buffer_length words
// (1 to MAX_DEPTH, 0 reads as 1, larger values saturate). An item with tuser 0
// inserts tdata, tuser 1 dumps the contents oldest first with tlast on the
// final word, tuser 2 clears; tuser 3 is accepted and ignored. A dump of an
// empty buffer returns one item with word 0, tuser 0 and tlast set. Inserts
// and clears sustain one item per cycle, while no dump holds the back end,
// through a two-entry command queue. A dump holds the back end while it
// issues one read per stored word (one result when empty), paced by the
// single read port of the word store and by room in the result queue. No
// clearing pass is needed after reset. Writing buffer_length empties the
// buffer; write it only while the block is idle.
// depends on orb_pkg, orb_front, orb_back, orb_ram
`default_nettype none

module overwrite_oldest_ring_buffer_core #(
    parameter int MAX_DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input items
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic signed [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic        [1:0]  s_axis_tuser,   // [1:0] mode
    // result items
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic signed      [31:0] m_axis_tdata,   // [31:0] word
    output logic                    m_axis_tuser,   // [0] valid_res
    output logic                    m_axis_tlast,
    // register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [2:0]  paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready
);

    import orb_pkg::*;

    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [LEN_W-1:0] buffer_length_reg;
    logic [LEN_W-1:0] buffer_length_next;
    logic             cfg_wr;
    logic             cfg_hit;
    logic [CMP_W-1:0] len_ext;
    logic [CNT_W-1:0] cap;
    logic             cmd_valid;
    logic             cmd_ready;
    cmd_t             cmd;

    // register port
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == REG_BUFFER_LENGTH);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? {{(32 - LEN_W){1'b0}}, buffer_length_reg} : 32'd0;

    assign buffer_length_next = cfg_wr ? pwdata[LEN_W-1:0] : buffer_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_length_reg <= LEN_RESET;
        end
        else
        begin
            buffer_length_reg <= buffer_length_next;
        end
    end

    // effective capacity, clamped to 1..MAX_DEPTH
    assign len_ext = CMP_W'(buffer_length_reg);

    always_comb
    begin
        if (len_ext == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (len_ext > CMP_W'(MAX_DEPTH))
        begin
            cap = CNT_W'(MAX_DEPTH);
        end
        else
        begin
            cap = CNT_W'(len_ext);
        end
    end

    orb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser),
        .in_value  (s_axis_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    orb_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap),
        .cfg_clear (cfg_wr),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (m_axis_tdata),
        .out_real  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

`ifndef SYNTH
    // a dump taken by the back end leaves it busy in the following cycle
    a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd.kind == CMD_DUMP) |=> !cmd_ready)
        else $error("back end ready right after starting a dump");

    // the empty marker is always the final result of its dump
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("empty result without tlast");

    // the command queue fills only through an accepted item
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("input stalled without an accepted item");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_overwrite_oldest_ring_buffer_core.sv -----
// self-checking testbench for the overwrite-oldest ring buffer core: a queued stream driver,
// a checking monitor against an in-bench ring model, and register writes over the apb port
// depends on orb_pkg and overwrite_oldest_ring_buffer_core
`timescale 1ns / 100ps

module tb_overwrite_oldest_ring_buffer_core;
    import orb_pkg::*;

    localparam int DEPTH         = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;

    // unused mode code and register addresses
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [2:0]        ADDR_LEN   = {REG_BUFFER_LENGTH, 2'b00};
    localparam logic [2:0]        ADDR_SPARE = {~REG_BUFFER_LENGTH, 2'b00};

    typedef struct {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] value;
    } ring_item_t;

    typedef struct {
        logic signed [WORD_W-1:0] word;
        logic                     valid_res;
        logic                     last;
    } dump_word_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic signed [WORD_W-1:0] s_axis_tdata  = '0;   // [31:0] value
    logic        [MODE_W-1:0] s_axis_tuser  = '0;   // [1:0] mode
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic signed [WORD_W-1:0] m_axis_tdata;         // [31:0] word
    logic                     m_axis_tuser;         // [0] valid_res
    logic                     m_axis_tlast;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic        [2:0]        paddr   = '0;
    logic        [31:0]       pwdata  = '0;
    logic        [31:0]       prdata;
    logic                     pready;

    // stimulus and expectation stores
    ring_item_t pending_items[$];
    ring_item_t next_item;
    dump_word_t dump_due[$];
    dump_word_t due_word;

    // ring model state
    logic [WORD_W-1:0] ring_words[DEPTH];
    int unsigned       ring_oldest = 0;
    int unsigned       ring_count  = 0;
    logic [LEN_W-1:0]  ring_len_reg = LEN_RESET;

    // traffic shaping
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests  = 0;
    int unsigned holds_served   = 0;
    int unsigned hold_left      = 0;

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    overwrite_oldest_ring_buffer_core #(
        .MAX_DEPTH(DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ring model: apply one accepted item, queue the dump words it produces
    task automatic ring_apply(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] value);
        int unsigned cap;
        dump_word_t  w;
        cap = (ring_len_reg == 0) ? 1 : ((ring_len_reg > DEPTH) ? DEPTH : ring_len_reg);
        if (mode == MODE_INSERT)
        begin
            // full: drop the oldest to make room
            while (ring_count >= cap)
            begin
                ring_oldest = (ring_oldest + 1) % DEPTH;
                ring_count--;
            end
            ring_words[(ring_oldest + ring_count) % DEPTH] = value;
            ring_count++;
        end
        else if (mode == MODE_DUMP)
        begin
            if (ring_count == 0)
            begin
                // empty buffer answers with one flagged item
                w.word      = '0;
                w.valid_res = 1'b0;
                w.last      = 1'b1;
                dump_due.push_back(w);
            end
            else
            begin
                for (int unsigned k = 0; k < ring_count; k++)
                begin
                    w.word      = ring_words[(ring_oldest + k) % DEPTH];
                    w.valid_res = 1'b1;
                    w.last      = (k + 1 == ring_count);
                    dump_due.push_back(w);
                end
            end
        end
        else if (mode == MODE_CLEAR)
        begin
            ring_oldest = 0;
            ring_count  = 0;
        end
    endtask

    // input driver: predicts on acceptance, then offers the next pending item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                ring_apply(s_axis_tuser, s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_item.value;
                    s_axis_tuser  <= next_item.mode;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started on request
    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor: compare each item with the oldest expected dump word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (dump_due.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < MAX_REPORTS)
                        $display("unexpected result: word %0d valid_res %0b last %0b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
                else
                begin
                    due_word = dump_due.pop_front();
                    if (m_axis_tdata !== due_word.word || m_axis_tuser !== due_word.valid_res
                        || m_axis_tlast !== due_word.last)
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < MAX_REPORTS)
                            $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     due_word.word, due_word.valid_res, due_word.last,
                                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end
            end
            m_axis_tready <= (hold_left != 0) ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic push_item(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] value);
        ring_item_t it;
        it.mode  = mode;
        it.value = value;
        pending_items.push_back(it);
    endtask

    // random items: mostly inserts with some dumps, few clears and unused codes
    task automatic queue_random_items(input int unsigned n);
        int unsigned       r;
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] value;
        for (int unsigned i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 72)
                mode = MODE_INSERT;
            else if (r < 90)
                mode = MODE_DUMP;
            else if (r < 95)
                mode = MODE_CLEAR;
            else
                mode = MODE_SPARE;
            case ($urandom_range(15))
                0:       value = 32'h7FFF_FFFF;
                1:       value = 32'h8000_0000;
                2:       value = 32'h0000_0000;
                3:       value = 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase
            push_item(mode, value);
        end
    endtask

    // wait until all items are in, all results out, and the pipeline has settled
    task automatic wait_quiet();
        while (pending_items.size() != 0 || s_axis_tvalid || dump_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup then access, model updated at the access edge
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr[2] == REG_BUFFER_LENGTH)
        begin
            ring_len_reg = data[LEN_W-1:0];
            ring_oldest  = 0;
            ring_count   = 0;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // set length (upper data bits random), traffic shape, then run random items
    task automatic run_phase(input logic [LEN_W-1:0] len, input int unsigned send_pct,
                             input int unsigned recv_pct, input int unsigned n);
        logic [31:0] data;
        data = $urandom;
        data[LEN_W-1:0] = len;
        write_reg(ADDR_LEN, data);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
        queue_random_items(n);
        wait_quiet();
    endtask

    // main sequence
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every mode, empty dump, overwrite at the reset length
        push_item(MODE_DUMP, 32'h0);
        push_item(MODE_INSERT, 32'h7FFF_FFFF);
        push_item(MODE_INSERT, 32'h8000_0000);
        push_item(MODE_INSERT, 32'h0000_0000);
        push_item(MODE_INSERT, 32'hFFFF_FFFF);
        push_item(MODE_SPARE, 32'h1234_5678);
        push_item(MODE_DUMP, 32'hFFFF_FFFF);
        push_item(MODE_CLEAR, 32'h5555_5555);
        push_item(MODE_DUMP, 32'h0);
        for (int i = 0; i < 10; i++)
            push_item(MODE_INSERT, $urandom);
        push_item(MODE_DUMP, 32'h0);
        push_item(MODE_INSERT, 32'hAAAA_AAAA);
        push_item(MODE_DUMP, 32'h0);
        wait_quiet();

        // zero length acts as one with no idling, then one with sender idling, then 64 with receiver stalls
        run_phase(7'd0, 0, 0, 40);
        run_phase(7'd1, 87, 0, 40);
        run_phase(7'd64, 0, 87, 40);

        // oversized length saturates; fill, then hold the receiver off
        write_reg(ADDR_LEN, 32'h0000_007F);
        recv_stall_pct <= 13;
        for (int i = 0; i < 70; i++)
            push_item(MODE_INSERT, $urandom);
        push_item(MODE_DUMP, 32'h0);
        hold_requests <= hold_requests + 1;
        send_idle_pct <= 0;
        for (int i = 0; i < 6; i++)
            push_item(MODE_INSERT, $urandom);
        push_item(MODE_DUMP, 32'h0);
        queue_random_items(20);
        wait_quiet();

        run_phase(7'd2, 13, 13, 40);

        // write to the spare address must leave contents and length alone
        queue_random_items(6);
        wait_quiet();
        write_reg(ADDR_SPARE, $urandom);
        push_item(MODE_DUMP, 32'h0);
        wait_quiet();

        run_phase(7'($urandom_range(63, 3)), 87, 87, 50);

        if (mismatch_count == 0 && dump_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/orb_pkg.sv
hdl/orb_ram.sv
hdl/orb_front.sv
hdl/orb_back.sv
hdl/overwrite_oldest_ring_buffer_core.sv
verif/tb_overwrite_oldest_ring_buffer_core.sv
